// ----- rtl/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int FRAC_DEF  = 32;

  typedef logic [2:0] func_t;
  typedef logic [2:0] status_t;

  // token kinds
  localparam func_t FN_PUSH = 3'd0;
  localparam func_t FN_ADD  = 3'd1;
  localparam func_t FN_SUB  = 3'd2;
  localparam func_t FN_MUL  = 3'd3;
  localparam func_t FN_DIV  = 3'd4;

  // result status codes
  localparam status_t STAT_OK      = 3'd0;
  localparam status_t STAT_EMPTY   = 3'd1;
  localparam status_t STAT_DIVZERO = 3'd2;
  localparam status_t STAT_FULL    = 3'd3;
  localparam status_t STAT_SAT     = 3'd4;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic go_mul;
    logic go_div;
    logic mul_done;
    logic div_done;
  } sts_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Apply sign to a 128-bit magnitude; bit 64 of the result flags saturation.
  function automatic logic [64:0] fit_signed(input logic neg, input logic [127:0] mag);
    logic [63:0] lim;
    logic [64:0] res;
    lim = neg ? Q_MIN : Q_MAX;
    if (mag[127:64] != 64'd0 || mag[63:0] > lim) begin
      res = {1'b1, lim};
    end else begin
      res = {1'b0, (neg ? (~mag[63:0] + 64'd1) : mag[63:0])};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rpn_mul.sv -----
`default_nettype none

module rpn_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a_mag,
  input  wire logic [63:0]  b_mag,
  output logic              done,
  output logic [127:0]      prod
);
  import rpn_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic         busy_r, busy_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic [63:0]  a_r, b_r;
  logic [63:0]  pp_r;
  logic [1:0]   pidx_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_shift;

  // four 32x32 partial products, one per cycle, each registered and summed in the cycle after
  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp     = 64'(a_half) * 64'(b_half);

  always_comb begin
    case (pidx_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd3:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = {32'd0, pp_r, 32'd0};
    endcase
  end

  assign done = busy_r && (cnt_r == LAST_STEP);
  assign prod = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
    end else if (busy_r) begin
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (!cnt_r[2]) begin
        pp_r   <= pp;
        pidx_r <= cnt_r[1:0];
      end
      if (cnt_r != 3'd0 && cnt_r != LAST_STEP) begin
        acc_r <= acc_r + pp_shift;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpn_div.sv -----
`default_nettype none

module rpn_div #(
  parameter int FRAC_BITS = rpn_pkg::FRAC_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a_mag,
  input  wire logic [63:0]  b_mag,
  output logic              done,
  output logic [127:0]      quo
);
  import rpn_pkg::*;

  localparam int NUM_W = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] n_r, q_r;
  logic [63:0]      d_r, rem_r;
  logic [64:0]      rem_sh, rem_sub;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, n_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign fits    = rem_sh >= {1'b0, d_r};

  assign done = busy_r && (cnt_r == '0);
  assign quo  = 128'(q_r);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= NUM_W'(a_mag) << FRAC_BITS;
      d_r   <= b_mag;
      rem_r <= 64'd0;
      q_r   <= '0;
    end else if (busy_r && cnt_r != '0) begin
      n_r   <= {n_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? rem_sub[63:0] : rem_sh[63:0];
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpn_dpath.sv -----
`default_nettype none

module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rpn_pkg::func_t        in_func,
  input  wire logic signed [31:0]    in_number,
  input  wire logic                  in_last,
  input  wire rpn_pkg::cmd_t         cmd,
  output rpn_pkg::sts_t              sts,
  output logic signed [63:0]         out_answer,
  output rpn_pkg::status_t           out_status
);
  import rpn_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // top of stack lives in tos_r; entries below it live in the memory
  logic [63:0]      mem [STACK_DEPTH];

  func_t            func_r;
  logic [31:0]      num_r;
  logic             last_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          err_r, err_nxt;
  logic [63:0]      tos_r, tos_nxt;
  logic [63:0]      rd_r;
  logic             neg_r;
  logic [63:0]      ans_r;
  status_t          stat_r;

  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic             wr_en;
  logic             hard, has_two, full;
  logic [63:0]      num_ext, push_val;
  logic [63:0]      sum, dif, sat_val;
  logic             add_ovf, sub_ovf;
  logic             go_mul, go_div;
  logic             mul_done, div_done;
  logic [127:0]     mul_prod, div_quo, mul_q;
  logic [64:0]      mul_fit, div_fit;
  logic [63:0]      a_mag, b_mag;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign cnt_m2  = count_r - CNT_W'(2);
  assign hard    = (err_r == STAT_EMPTY) || (err_r == STAT_DIVZERO) || (err_r == STAT_FULL);
  assign has_two = count_r >= CNT_W'(2);
  assign full    = count_r == CNT_W'(STACK_DEPTH);

  assign num_ext  = {{32{num_r[31]}}, num_r};
  assign push_val = num_ext << FRAC_BITS;

  assign sum     = rd_r + tos_r;
  assign dif     = rd_r - tos_r;
  assign add_ovf = ~(rd_r[63] ^ tos_r[63]) & (sum[63] ^ rd_r[63]);
  assign sub_ovf = (rd_r[63] ^ tos_r[63]) & (dif[63] ^ rd_r[63]);
  assign sat_val = rd_r[63] ? Q_MIN : Q_MAX;

  assign go_mul = !hard && (func_r == FN_MUL) && has_two;
  assign go_div = !hard && (func_r == FN_DIV) && has_two && (tos_r != 64'd0);

  assign a_mag = mag64(rd_r);
  assign b_mag = mag64(tos_r);

  assign mul_q   = mul_prod >> FRAC_BITS;
  assign mul_fit = fit_signed(neg_r, mul_q);
  assign div_fit = fit_signed(neg_r, div_quo);

  rpn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.exec && go_mul),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rpn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.exec && go_div),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sts.last     = last_r;
    sts.go_mul   = go_mul;
    sts.go_div   = go_div;
    sts.mul_done = mul_done;
    sts.div_done = div_done;
  end

  always_comb begin
    count_nxt = count_r;
    err_nxt   = err_r;
    tos_nxt   = tos_r;
    wr_en     = 1'b0;
    if (cmd.exec && !hard) begin
      // without a hard error held, err_r is either ok or saturated
      case (func_r)
        FN_PUSH: begin
          if (full) begin
            err_nxt = STAT_FULL;
          end else begin
            wr_en     = count_r != '0;
            tos_nxt   = push_val;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_ADD, FN_SUB: begin
          if (!has_two) begin
            err_nxt = STAT_EMPTY;
          end else begin
            count_nxt = cnt_m1;
            if (func_r == FN_ADD) begin
              tos_nxt = add_ovf ? sat_val : sum;
            end else begin
              tos_nxt = sub_ovf ? sat_val : dif;
            end
            if (((func_r == FN_ADD) ? add_ovf : sub_ovf) && err_r == STAT_OK) begin
              err_nxt = STAT_SAT;
            end
          end
        end
        FN_MUL: begin
          if (!has_two) begin
            err_nxt = STAT_EMPTY;
          end
        end
        FN_DIV: begin
          if (!has_two) begin
            err_nxt = STAT_EMPTY;
          end else if (tos_r == 64'd0) begin
            err_nxt = STAT_DIVZERO;
          end
        end
        default: ;
      endcase
    end else if (mul_done || div_done) begin
      tos_nxt   = mul_done ? mul_fit[63:0] : div_fit[63:0];
      count_nxt = cnt_m1;
      if ((mul_done ? mul_fit[64] : div_fit[64]) && err_r == STAT_OK) begin
        err_nxt = STAT_SAT;
      end
    end else if (cmd.emit) begin
      count_nxt = '0;
      err_nxt   = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= STAT_OK;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (cmd.load) begin
      func_r <= in_func;
      num_r  <= in_number;
      last_r <= in_last;
    end
    if (cmd.exec) begin
      neg_r <= rd_r[63] ^ tos_r[63];
    end
    if (cmd.emit) begin
      if (hard) begin
        ans_r  <= 64'd0;
        stat_r <= err_r;
      end else if (count_r == '0) begin
        ans_r  <= 64'd0;
        stat_r <= STAT_EMPTY;
      end else begin
        ans_r  <= tos_r;
        stat_r <= err_r;
      end
    end
  end

  // stack store: push writes the old top below the new one; the second
  // entry is read when the token is taken
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_m1[ADDR_W-1:0]] <= tos_r;
    end
    if (cmd.load) begin
      rd_r <= mem[cnt_m2[ADDR_W-1:0]];
    end
  end

  assign out_answer = ans_r;
  assign out_status = stat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0) && (err_r == STAT_OK))
    else $error("stack not cleared after result");

  a_unit_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done) |-> has_two && !hard)
    else $error("arithmetic unit finished without two operands");

endmodule

`default_nettype wire

// ----- rtl/rpn_ctrl.sv -----
`default_nettype none

module rpn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rpn_pkg::cmd_t      cmd,
  input  wire rpn_pkg::sts_t sts
);
  import rpn_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.go_mul) begin
          state_nxt = ST_MUL;
        end else if (sts.go_div) begin
          state_nxt = ST_DIV;
        end else if (sts.last) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (sts.mul_done) begin
          state_nxt = sts.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == ST_IDLE;
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.exec = state_r == ST_EXEC;
    cmd.emit = (state_r == ST_EMIT) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $past(in_valid && in_ready))
    else $error("execute without an accepted item");

  a_no_stray_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> !sts.div_done)
    else $error("divider finished during multiply");

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_evaluator.sv -----
// Postfix (RPN) evaluator over a bounded stack of signed Q32.32 values.
// Input channel (in_valid/in_ready): one token per item. in_func 0 pushes
// in_number scaled by 2^FRAC_BITS; 1..4 pop b, then a, and push a+b, a-b,
// a*b or a/b, saturating on overflow. Codes 5..7 are ignored. in_last marks
// the final token of an expression.
// Result channel (out_valid/out_ready): one item per expression, after its
// last token: out_answer is the top of stack (0 unless the status is ok or
// saturated), out_status is 0 ok, 1 stack empty, 2 divide by zero, 3 stack
// full, 4 saturated. The stack and the error are then cleared.
// Sequence: push, add, subtract and ignored tokens are loaded, then executed;
// multiply then waits for the multiplier (four 32x32 partial products,
// one per cycle); divide waits for the divider's one bit per cycle loop.
// A last token then passes the emit state to load the result register.
// One token is in work at a time.
// Reset: empty stack, no error, no result pending. The stack memory is not
// cleared; only written entries are ever used.
// Stall: a pending result waits in the output register while further tokens
// are taken; the next result waits until that one has been taken.
`default_nettype none

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rpn_pkg::func_t      in_func,
  input  wire logic signed [31:0]  in_number,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [63:0]       out_answer,
  output rpn_pkg::status_t         out_status
);
  import rpn_pkg::*;

  // sequencer commands toward the datapath, status back
  cmd_t cmd;
  sts_t sts;

  // hold the handshake and step each token through execute, wait, emit
  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stack store, top-of-stack register, arithmetic units, result register
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_number  (in_number),
    .in_last    (in_last),
    .cmd        (cmd),
    .sts        (sts),
    .out_answer (out_answer),
    .out_status (out_status)
  );

endmodule

`default_nettype wire
